// ===== design/fsu_pkg.sv =====
`default_nettype none

package fsu_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [2:0] MAT_AIR   = 3'd0;
   localparam logic [2:0] MAT_SAND  = 3'd1;
   localparam logic [2:0] MAT_WATER = 3'd2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int BOUND_W    = 9;

   localparam logic [BOUND_W-1:0] BOUND_RESET = 9'd256;

   // Register index is the word address bit.
   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   // Cells the probe unit can address; an update tries the neighbours in the order listed.
   typedef enum logic [2:0] {
      PROBE_BELOW     = 3'd0,
      PROBE_NEAR_DIAG = 3'd1,
      PROBE_FAR_DIAG  = 3'd2,
      PROBE_FAR_SIDE  = 3'd3,
      PROBE_NEAR_SIDE = 3'd4,
      PROBE_CENTER    = 3'd5
   } probe_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] cell_x;
      logic [7:0] cell_y;
      logic [2:0] material_in;
      logic       side_first;
   } req_type;

   typedef struct packed {
      logic [2:0] material_out;
      logic       moved;
      logic [7:0] dest_x;
      logic [7:0] dest_y;
   } rsp_type;

   typedef struct packed {
      logic       in_store;
      logic       in_active;
      logic [7:0] nx;
      logic [7:0] ny;
   } probe_info_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

`default_nettype wire

// ===== design/falling_sand_cell_update_unit.sv =====
// Falling-sand cell update unit: keeps a grid of material codes in one single-port memory and
// serves write, read and update requests, one at a time, with one response each. A write or a
// read touches only the addressed cell. An update reads the addressed cell, then reads each
// neighbour probed (a neighbour outside the bounds is skipped without a read), and on a swap
// writes the swapped pair. The single memory port is shared by every read and write of a request.
// The grid memory is not cleared at reset; every cell must be written before it is read.
// The bounds registers sit at byte addresses 0 (columns) and 4 (rows).
`default_nettype none

module falling_sand_cell_update_unit #(
   parameter int GRID_WIDTH    = 256,
   parameter int GRID_HEIGHT   = 256,
   parameter int MATERIAL_BITS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fsu_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fsu_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fsu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fsu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fsu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import fsu_pkg::*;

   logic [BOUND_W-1:0] cols_ff;
   logic [BOUND_W-1:0] rows_ff;
   logic               csr_write;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               out_free;
   logic               start;
   seq_status_type     status;
   rsp_type            result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= BOUND_RESET;
         rows_ff <= BOUND_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_COLUMNS) begin
            cols_ff <= csr_pwdata[BOUND_W-1:0];
         end else begin
            rows_ff <= csr_pwdata[BOUND_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_COLUMNS)
                       ? CSR_DATA_W'(cols_ff) : CSR_DATA_W'(rows_ff);

   assign req_stall = status.busy;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   fsu_sequencer #(
      .GRID_WIDTH    (GRID_WIDTH),
      .GRID_HEIGHT   (GRID_HEIGHT),
      .MATERIAL_BITS (MATERIAL_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (req_data),
      .cols     (cols_ff),
      .rows     (rows_ff),
      .out_free (out_free),
      .status   (status),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= result;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !status.done)
      else $error("response finished while output register held a stalled response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted request did not make the sequencer busy");

   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> $past(status.done))
      else $error("sequencer went idle without delivering a response");

endmodule

`default_nettype wire

// ===== design/fsu_probe_unit.sv =====
`default_nettype none

module fsu_probe_unit #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int ADDR_W      = 16
) (
   input  logic [7:0]                     cell_x,
   input  logic [7:0]                     cell_y,
   input  logic                           side_first,
   input  fsu_pkg::probe_type             probe,
   input  logic [fsu_pkg::BOUND_W-1:0]    cols,
   input  logic [fsu_pkg::BOUND_W-1:0]    rows,
   output logic [ADDR_W-1:0]              addr,
   output fsu_pkg::probe_info_type        info
);
   import fsu_pkg::*;

   logic signed [9:0] near_step;
   logic signed [9:0] dx;
   logic signed [9:0] dy;
   logic signed [9:0] nx;
   logic signed [9:0] ny;
   logic              x_in_grid;
   logic              y_in_grid;
   logic              x_in_use;
   logic              y_in_use;

   assign near_step = side_first ? 10'sd1 : -10'sd1;

   always_comb begin
      unique case (probe)
         PROBE_BELOW: begin
            dx = 10'sd0;
            dy = 10'sd1;
         end
         PROBE_NEAR_DIAG: begin
            dx = near_step;
            dy = 10'sd1;
         end
         PROBE_FAR_DIAG: begin
            dx = -near_step;
            dy = 10'sd1;
         end
         PROBE_FAR_SIDE: begin
            dx = -near_step;
            dy = 10'sd0;
         end
         PROBE_NEAR_SIDE: begin
            dx = near_step;
            dy = 10'sd0;
         end
         default: begin
            dx = 10'sd0;
            dy = 10'sd0;
         end
      endcase
   end

   assign nx = $signed({2'b00, cell_x}) + dx;
   assign ny = $signed({2'b00, cell_y}) + dy;

   assign x_in_grid = !nx[9] && (32'(nx[8:0]) < 32'(GRID_WIDTH));
   assign y_in_grid = !ny[9] && (32'(ny[8:0]) < 32'(GRID_HEIGHT));
   assign x_in_use  = !nx[9] && (nx[8:0] < cols);
   assign y_in_use  = !ny[9] && (ny[8:0] < rows);

   assign info.in_store  = x_in_grid && y_in_grid;
   assign info.in_active = x_in_grid && y_in_grid && x_in_use && y_in_use;
   assign info.nx        = nx[7:0];
   assign info.ny        = ny[7:0];

   // Row-major cell address; only meaningful when the cell is in the store.
   assign addr = ADDR_W'(32'(ny[8:0]) * 32'(GRID_WIDTH) + 32'(nx[8:0]));

endmodule

`default_nettype wire

// ===== design/fsu_sequencer.sv =====
`default_nettype none

module fsu_sequencer #(
   parameter int GRID_WIDTH    = 256,
   parameter int GRID_HEIGHT   = 256,
   parameter int MATERIAL_BITS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  fsu_pkg::req_type              item,
   input  logic [fsu_pkg::BOUND_W-1:0]   cols,
   input  logic [fsu_pkg::BOUND_W-1:0]   rows,
   input  logic                          out_free,
   output fsu_pkg::seq_status_type       status,
   output fsu_pkg::rsp_type              result
);
   import fsu_pkg::*;

   localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MB     = MATERIAL_BITS;
   localparam int MEXT   = MATERIAL_BITS + 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_HERE,
      ST_PROBE,
      ST_TEST,
      ST_WR_NEAR,
      ST_WR_HOME,
      ST_DONE
   } state_type;

   function automatic logic [2:0] to_port(input logic [MB-1:0] v);
      logic [MEXT-1:0] t;
      t = {3'b000, v};
      return t[2:0];
   endfunction

   function automatic logic [MB-1:0] to_store(input logic [2:0] m);
      logic [MEXT-1:0] t;
      t = {{MB{1'b0}}, m};
      return t[MB-1:0];
   endfunction

   function automatic logic is_code(input logic [MB-1:0] v, input logic [2:0] code);
      return {3'b000, v} == MEXT'(code);
   endfunction

   logic [MB-1:0]  mem [DEPTH];

   state_type      state_ff;
   req_type        item_ff;
   probe_type      try_ff;
   logic [MB-1:0]  here_ff;
   logic [MB-1:0]  other_ff;
   logic [MB-1:0]  rd_ff;
   rsp_type        result_ff;

   probe_type      probe_sel;
   logic [ADDR_W-1:0] addr;
   probe_info_type info;
   logic           mem_we;
   logic           mem_re;
   logic [MB-1:0]  mem_wdata;
   logic           here_sand;
   logic           last_try;
   logic           swap_ok;

   fsu_probe_unit #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .ADDR_W      (ADDR_W)
   ) u_probe (
      .cell_x     (item_ff.cell_x),
      .cell_y     (item_ff.cell_y),
      .side_first (item_ff.side_first),
      .probe      (probe_sel),
      .cols       (cols),
      .rows       (rows),
      .addr       (addr),
      .info       (info)
   );

   assign probe_sel = (state_ff == ST_PROBE || state_ff == ST_TEST || state_ff == ST_WR_NEAR)
                      ? try_ff : PROBE_CENTER;

   assign here_sand = is_code(here_ff, MAT_SAND);
   assign last_try  = here_sand ? (try_ff == PROBE_FAR_DIAG) : (try_ff == PROBE_NEAR_SIDE);
   assign swap_ok   = is_code(rd_ff, MAT_AIR) || (here_sand && is_code(rd_ff, MAT_WATER));

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = here_ff;
      unique case (state_ff)
         ST_CENTER: begin
            mem_we    = (item_ff.operation == OP_WRITE) && info.in_store;
            mem_re    = (item_ff.operation == OP_READ || item_ff.operation == OP_UPDATE)
                        && info.in_store;
            mem_wdata = to_store(item_ff.material_in);
         end
         ST_PROBE:   mem_re = info.in_active;
         ST_WR_NEAR: mem_we = 1'b1;
         ST_WR_HOME: begin
            mem_we    = 1'b1;
            mem_wdata = other_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  item_ff  <= item;
                  state_ff <= ST_CENTER;
               end
            end
            ST_CENTER: begin
               result_ff.material_out <= MAT_AIR;
               result_ff.moved        <= 1'b0;
               result_ff.dest_x       <= item_ff.cell_x;
               result_ff.dest_y       <= item_ff.cell_y;
               if (item_ff.operation == OP_READ || item_ff.operation == OP_UPDATE) begin
                  state_ff <= ST_HERE;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_HERE: begin
               here_ff <= rd_ff;
               try_ff  <= PROBE_BELOW;
               if (info.in_store) begin
                  result_ff.material_out <= to_port(rd_ff);
               end
               if (item_ff.operation == OP_UPDATE && info.in_active
                   && (is_code(rd_ff, MAT_SAND) || is_code(rd_ff, MAT_WATER))) begin
                  state_ff <= ST_PROBE;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_PROBE: begin
               // Skip cells outside the bounds without a read.
               if (info.in_active) begin
                  state_ff <= ST_TEST;
               end else if (last_try) begin
                  state_ff <= ST_DONE;
               end else begin
                  try_ff <= probe_type'(try_ff + 3'd1);
               end
            end
            ST_TEST: begin
               if (swap_ok) begin
                  other_ff         <= rd_ff;
                  result_ff.moved  <= 1'b1;
                  result_ff.dest_x <= info.nx;
                  result_ff.dest_y <= info.ny;
                  state_ff         <= ST_WR_NEAR;
               end else if (last_try) begin
                  state_ff <= ST_DONE;
               end else begin
                  try_ff   <= probe_type'(try_ff + 3'd1);
                  state_ff <= ST_PROBE;
               end
            end
            ST_WR_NEAR: state_ff <= ST_WR_HOME;
            ST_WR_HOME: state_ff <= ST_DONE;
            ST_DONE: begin
               // Hold until the output register can take the response.
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE) && out_free;
   assign result      = result_ff;

endmodule

`default_nettype wire

// ===== dv/falling_sand_cell_update_unit_test.sv =====
module falling_sand_cell_update_unit_test;
   import fsu_pkg::*;

   localparam int GRID_COLS = 256;
   localparam int GRID_ROWS = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] MAT_ROCK = 3'd7;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 7;

   typedef struct packed {
      req_type req;
      logic    drain_first;
   } cell_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cell_request_type cell_requests[$];
   rsp_type expected_cells[$];
   logic [2:0] grid_model[GRID_COLS*GRID_ROWS];
   bit cell_written[GRID_COLS*GRID_ROWS];
   logic [BOUND_W-1:0] model_cols = BOUND_RESET;
   logic [BOUND_W-1:0] model_rows = BOUND_RESET;

   // bounds per phase; phase 0 keeps the reset values, the last one is drawn at random
   int phase_cols[PHASES] = '{0, 511, 1, 0, 200, 256, 0};
   int phase_rows[PHASES] = '{0, 511, 200, 0, 1, 256, 0};
   int phase_items[PHASES] = '{200, 250, 200, 100, 250, 300, 300};
   int phase_send_idle[PHASES] = '{13, 13, 71, 71, 71, 0, 0};
   int phase_stall[PHASES] = '{71, 71, 13, 13, 13, 0, 0};

   int send_idle_pct = 0;
   int stall_pct = 0;
   bit req_taken = 1'b0;
   int fail_count = 0;
   int checked_count = 0;
   int moved_count = 0;
   int queued_count = 0;
   int watch_cycles;

   falling_sand_cell_update_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   function automatic rsp_type predict_cell_update(req_type r);
      rsp_type res;
      int cols, rows, x, y, d, nx, ny, tries;
      int step_x[5];
      int step_y[5];
      logic [2:0] here, there;
      res.material_out = MAT_AIR;
      res.moved = 1'b0;
      res.dest_x = r.cell_x;
      res.dest_y = r.cell_y;
      cols = (model_cols > GRID_COLS) ? GRID_COLS : model_cols;
      rows = (model_rows > GRID_ROWS) ? GRID_ROWS : model_rows;
      x = r.cell_x;
      y = r.cell_y;
      d = r.side_first ? 1 : -1;
      // below, near diagonal, far diagonal, far side, near side
      step_x = '{0, d, -d, -d, d};
      step_y = '{1, 1, 1, 0, 0};
      case (r.operation)
         OP_WRITE: grid_model[y*GRID_COLS + x] = r.material_in;
         OP_READ: res.material_out = grid_model[y*GRID_COLS + x];
         OP_UPDATE: begin
            here = grid_model[y*GRID_COLS + x];
            res.material_out = here;
            if (x < cols && y < rows && (here == MAT_SAND || here == MAT_WATER)) begin
               tries = (here == MAT_SAND) ? 3 : 5;
               for (int k = 0; k < tries && !res.moved; k++) begin
                  nx = x + step_x[k];
                  ny = y + step_y[k];
                  if (nx >= 0 && ny >= 0 && nx < cols && ny < rows) begin
                     there = grid_model[ny*GRID_COLS + nx];
                     if (there == MAT_AIR || (here == MAT_SAND && there == MAT_WATER)) begin
                        grid_model[ny*GRID_COLS + nx] = here;
                        grid_model[y*GRID_COLS + x] = there;
                        res.moved = 1'b1;
                        res.dest_x = 8'(nx);
                        res.dest_y = 8'(ny);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [2:0] random_material();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return MAT_AIR;
      if (pick < 60) return MAT_SAND;
      if (pick < 85) return MAT_WATER;
      return 3'($urandom_range(7, 3));
   endfunction

   function automatic int window_base(logic [BOUND_W-1:0] bound, int grid);
      int lim;
      lim = (bound > grid) ? grid : bound;
      case ($urandom_range(3))
         0: return 0;
         1: return grid - 6;
         2: return (lim < 3) ? 0 : ((lim - 3 > grid - 6) ? grid - 6 : lim - 3);
         default: return $urandom_range(grid - 6);
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   task automatic queue_request(logic [1:0] op, int x, int y, logic [2:0] mat, logic side,
                                bit drain = 1'b0);
      cell_request_type item;
      item.req.operation = op;
      item.req.cell_x = 8'(x);
      item.req.cell_y = 8'(y);
      item.req.material_in = mat;
      item.req.side_first = side;
      item.drain_first = drain;
      if (op == OP_WRITE) cell_written[y*GRID_COLS + x] = 1'b1;
      cell_requests.push_back(item);
      queued_count++;
   endtask

   // the grid store has no reset value: fill a cell before anything can read it
   task automatic ensure_written(int x, int y);
      if (x >= 0 && y >= 0 && x < GRID_COLS && y < GRID_ROWS && !cell_written[y*GRID_COLS + x])
         queue_request(OP_WRITE, x, y, random_material(), 1'($urandom_range(1)));
   endtask

   task automatic queue_update(int x, int y, logic side, bit drain = 1'b0);
      for (int dy = 0; dy <= 1; dy++)
         for (int dx = -1; dx <= 1; dx++)
            ensure_written(x + dx, y + dy);
      queue_request(OP_UPDATE, x, y, random_material(), side, drain);
   endtask

   // count includes the fill writes that reads and updates pull in
   task automatic queue_random_requests(int count);
      int base_x, base_y, x, y, pick, start_count, n;
      logic side;
      bit drain;
      start_count = queued_count;
      n = 0;
      while (queued_count - start_count < count) begin
         // keep activity in a small window so cells pile up and interact
         if (n % 32 == 0) begin
            base_x = window_base(model_cols, GRID_COLS);
            base_y = window_base(model_rows, GRID_ROWS);
         end
         x = base_x + $urandom_range(5);
         y = base_y + $urandom_range(5);
         side = 1'($urandom_range(1));
         drain = (n == count / 8);
         pick = $urandom_range(99);
         if (pick < 22) begin
            queue_request(OP_WRITE, x, y, random_material(), side, drain);
         end else if (pick < 40) begin
            ensure_written(x, y);
            queue_request(OP_READ, x, y, 3'($urandom_range(7)), side, drain);
         end else if (pick < 96) begin
            queue_update(x, y, side, drain);
         end else begin
            queue_request(OP_UNUSED, x, y, 3'($urandom_range(7)), side, drain);
         end
         n++;
      end
   endtask

   task automatic write_bound(logic which, logic [BOUND_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[BOUND_W-1:0] !== value) begin
         $error("bound register readback: expected %0d, got %0d", value,
                csr_prdata[BOUND_W-1:0]);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (which == REG_COLUMNS) model_cols = value;
      else model_rows = value;
   endtask

   task automatic wait_until_drained();
      while (cell_requests.size() > 0 || req_valid || expected_cells.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // hold a marked request until every earlier response is back
         if (cell_requests.size() > 0
             && !(cell_requests[0].drain_first && expected_cells.size() > 0)
             && $urandom_range(99) >= send_idle_pct) begin
            req_data <= cell_requests[0].req;
            req_valid <= 1'b1;
            cell_requests.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("response with no request outstanding: material_out %0d dest (%0d,%0d)",
                      rsp_data.material_out, rsp_data.dest_x, rsp_data.dest_y);
               fail_count++;
            end else begin
               check_field("material_out", 8'(expected_cells[0].material_out),
                           8'(rsp_data.material_out));
               check_field("moved", 8'(expected_cells[0].moved), 8'(rsp_data.moved));
               check_field("dest_x", expected_cells[0].dest_x, rsp_data.dest_x);
               check_field("dest_y", expected_cells[0].dest_y, rsp_data.dest_y);
               if (expected_cells[0].moved) moved_count++;
               checked_count++;
               expected_cells.delete(0);
            end
         end
         if (req_valid && !req_stall)
            expected_cells.push_back(predict_cell_update(req_data));
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = phase_send_idle[p];
         stall_pct = phase_stall[p];
         if (p == PHASES - 1) begin
            phase_cols[p] = $urandom_range(256, 1);
            phase_rows[p] = $urandom_range(256, 1);
         end
         if (p > 0) begin
            write_bound(REG_COLUMNS, phase_cols[p][BOUND_W-1:0]);
            write_bound(REG_ROWS, phase_rows[p][BOUND_W-1:0]);
         end else begin
            // bottom left corner: sand sinks into water, then the water slides sideways
            queue_request(OP_WRITE, 0, 254, MAT_SAND, 1'b0);
            queue_request(OP_WRITE, 1, 254, MAT_AIR, 1'b1);
            queue_request(OP_WRITE, 0, 255, MAT_WATER, 1'b0);
            queue_request(OP_WRITE, 1, 255, MAT_ROCK, 1'b1);
            queue_update(0, 254, 1'b0);
            queue_update(0, 254, 1'b1);
            queue_update(0, 255, 1'b0);
            queue_request(OP_READ, 1, 254, MAT_ROCK, 1'b0);
            // bottom right corner: preferred diagonal falls off the grid
            queue_request(OP_WRITE, 255, 254, MAT_SAND, 1'b0);
            queue_request(OP_WRITE, 254, 255, MAT_AIR, 1'b1);
            queue_request(OP_WRITE, 255, 255, MAT_SAND, 1'b0);
            queue_request(OP_WRITE, 254, 254, MAT_WATER, 1'b1);
            queue_update(255, 254, 1'b1);
            queue_update(255, 255, 1'b1);
            queue_request(OP_WRITE, 255, 255, MAT_ROCK, 1'b1);
            queue_update(255, 255, 1'b0);
            queue_request(OP_UNUSED, 255, 255, MAT_ROCK, 1'b1);
            queue_request(OP_READ, 255, 255, MAT_AIR, 1'b0);
            // mid grid: below is solid, take the preferred diagonal
            queue_request(OP_WRITE, 127, 128, MAT_AIR, 1'b0);
            queue_request(OP_WRITE, 128, 128, MAT_ROCK, 1'b0);
            queue_request(OP_WRITE, 129, 128, MAT_AIR, 1'b1);
            queue_request(OP_WRITE, 127, 127, MAT_AIR, 1'b0);
            queue_request(OP_WRITE, 129, 127, MAT_WATER, 1'b1);
            queue_request(OP_WRITE, 128, 127, MAT_SAND, 1'b0);
            queue_update(128, 127, 1'b1);
         end
         queue_random_requests(phase_items[p]);
         wait_until_drained();
      end
      $display("%0d responses checked over %0d bound settings, %0d of them moved a cell",
               checked_count, PHASES, moved_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
         @(posedge clock);
      $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
